// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and rst_n to be visible where they are used.

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/faa_pkg.sv =====
package faa_pkg;

    localparam int unsigned MAX_BLOCKS_DEF      = 256;
    localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;

    localparam int unsigned NUM_BLOCKS_W = 9;
    localparam int unsigned BLOCK_SIZE_W = 13;
    localparam int unsigned INDEX_W      = 8;
    localparam int unsigned OFFSET_W     = 20;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned PDATA_W      = 32;

    typedef logic [NUM_BLOCKS_W-1:0] nblk_t;
    typedef logic [BLOCK_SIZE_W-1:0] bsz_t;
    typedef logic [COUNT_W-1:0]      count_t;

    localparam nblk_t NUM_BLOCKS_RST = 9'd256;
    localparam bsz_t  BLOCK_SIZE_RST = 13'd32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        REG_NUM_BLOCKS = 1'b0,
        REG_BLOCK_SIZE = 1'b1
    } reg_index_t;

    typedef struct packed {
        command_t             command;
        logic [INDEX_W-1:0]   free_index;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   block_index;
        logic [OFFSET_W-1:0]  byte_offset;
        status_t              status;
        count_t               free_count;
    } rsp_t;

    // Register values as seen by the pool logic, plus the rebuild strobe and the rebuild count.
    typedef struct packed {
        nblk_t  num_blocks;
        bsz_t   block_size;
        logic   rebuild;
        count_t rebuild_total;
    } cfg_t;

    typedef struct packed {
        logic fire;
        req_t req;
    } op_t;

    function automatic nblk_t clamp_num(nblk_t v, int unsigned limit);
        return (32'(v) > limit) ? nblk_t'(limit) : v;
    endfunction

    function automatic bsz_t clamp_bsz(bsz_t v, int unsigned limit);
        return (32'(v) > limit) ? bsz_t'(limit) : v;
    endfunction

endpackage

// ===== rtl/faa_req_if.sv =====
interface faa_req_if;
    logic          valid;
    logic          ready;
    faa_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/faa_rsp_if.sv =====
interface faa_rsp_if;
    logic          valid;
    logic          ready;
    faa_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/faa_ram.sv =====
module faa_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/faa_cfg_regs.sv =====
module faa_cfg_regs #(
    parameter int unsigned MAX_BLOCKS      = faa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned MAX_BLOCK_BYTES = faa_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [faa_pkg::PADDR_W-1:0]  paddr,
    input  logic [faa_pkg::PDATA_W-1:0]  pwdata,
    output logic [faa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output faa_pkg::cfg_t                cfg
);

    localparam faa_pkg::nblk_t NumReset =
        faa_pkg::clamp_num(faa_pkg::NUM_BLOCKS_RST, MAX_BLOCKS);
    localparam faa_pkg::bsz_t BszReset =
        faa_pkg::clamp_bsz(faa_pkg::BLOCK_SIZE_RST, MAX_BLOCK_BYTES);

    faa_pkg::nblk_t      num_blocks_reg, num_blocks_next;
    faa_pkg::bsz_t       block_size_reg, block_size_next;
    faa_pkg::reg_index_t sel;
    logic                write;

    assign write  = psel && penable && pwrite;
    assign sel    = faa_pkg::reg_index_t'(paddr[2]);
    assign pready = 1'b1;

    always_comb
    begin
        num_blocks_next = num_blocks_reg;
        block_size_next = block_size_reg;
        if (write)
        begin
            unique case (sel)
                faa_pkg::REG_NUM_BLOCKS:
                begin
                    num_blocks_next = faa_pkg::clamp_num(
                        pwdata[faa_pkg::NUM_BLOCKS_W-1:0], MAX_BLOCKS);
                end
                faa_pkg::REG_BLOCK_SIZE:
                begin
                    block_size_next = faa_pkg::clamp_bsz(
                        pwdata[faa_pkg::BLOCK_SIZE_W-1:0], MAX_BLOCK_BYTES);
                end
                default:
                begin
                    num_blocks_next = num_blocks_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            faa_pkg::REG_NUM_BLOCKS: prdata = faa_pkg::PDATA_W'(num_blocks_reg);
            faa_pkg::REG_BLOCK_SIZE: prdata = faa_pkg::PDATA_W'(block_size_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= NumReset;
            block_size_reg <= BszReset;
        end
        else
        begin
            num_blocks_reg <= num_blocks_next;
            block_size_reg <= block_size_next;
        end
    end

    // Any register write rebuilds the list, taking the count from the new num_blocks value.
    assign cfg.num_blocks    = num_blocks_reg;
    assign cfg.block_size    = block_size_reg;
    assign cfg.rebuild       = write;
    assign cfg.rebuild_total = faa_pkg::count_t'(num_blocks_next);

endmodule

// ===== rtl/faa_free_list.sv =====
`include "assert_macros.svh"

module faa_free_list #(
    parameter int unsigned MAX_BLOCKS = faa_pkg::MAX_BLOCKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  faa_pkg::cfg_t cfg,
    input  faa_pkg::op_t  op,
    output faa_pkg::rsp_t rsp
);

    localparam int unsigned HeadW      = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned StoreDepth =
        (MAX_BLOCKS < (2 ** faa_pkg::INDEX_W)) ? MAX_BLOCKS : (2 ** faa_pkg::INDEX_W);
    localparam int unsigned AddrW      = $clog2(StoreDepth);

    localparam faa_pkg::count_t CountReset = faa_pkg::count_t'(
        faa_pkg::clamp_num(faa_pkg::NUM_BLOCKS_RST, MAX_BLOCKS));

    typedef logic [HeadW-1:0] head_t;

    head_t           head_reg, head_next;
    faa_pkg::count_t count_reg, count_next, count_op;
    logic            fwd_reg, fwd_next;
    head_t           fwd_data_reg;
    logic            rd_valid_reg, rd_valid_next;
    logic            valid_reg [StoreDepth];

    logic             we;
    logic [AddrW-1:0] waddr, raddr;
    head_t            ram_rdata;
    head_t            succ;

    logic        is_alloc, empty, range_err, alloc_ok, free_ok, head_live;
    logic        alloc_fire;
    logic [31:0] head_wide, product;

    faa_ram #(
        .WIDTH (HeadW),
        .DEPTH (StoreDepth)
    ) u_next_free (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (head_reg),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // The link store is read at the head every cycle. A push in the previous
    // cycle wrote the very entry being read, so its value is forwarded.
    // Entries never written since the last rebuild link to their index plus one.
    always_comb
    begin
        if (fwd_reg)
        begin
            succ = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            succ = ram_rdata;
        end
        else
        begin
            succ = head_t'(head_reg + 1'b1);
        end
    end

    assign is_alloc  = (op.req.command == faa_pkg::CMD_ALLOC);
    assign empty     = (count_reg == '0);
    assign range_err = ({1'b0, op.req.free_index} >= cfg.num_blocks)
                    || (32'(op.req.free_index) >= MAX_BLOCKS);
    assign alloc_ok  = is_alloc && !empty;
    assign free_ok   = !is_alloc && !range_err;
    assign head_live = (32'(head_reg) < MAX_BLOCKS);
    assign waddr     = op.req.free_index[AddrW-1:0];
    assign we        = op.fire && free_ok && !cfg.rebuild;
    assign alloc_fire = op.fire && alloc_ok && !cfg.rebuild;

    always_comb
    begin
        count_op = count_reg;
        if (alloc_ok)
        begin
            count_op = count_reg - 1'b1;
        end
        else if (free_ok && ({1'b0, count_reg} < {1'b0, cfg.num_blocks}))
        begin
            count_op = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        fwd_next   = 1'b0;
        if (cfg.rebuild)
        begin
            head_next  = '0;
            count_next = cfg.rebuild_total;
        end
        else if (op.fire)
        begin
            count_next = count_op;
            if (alloc_ok && head_live)
            begin
                head_next = succ;
            end
            else if (free_ok)
            begin
                head_next = head_t'(op.req.free_index);
                fwd_next  = 1'b1;
            end
        end
    end

    assign raddr = head_next[AddrW-1:0];

    always_comb
    begin
        rd_valid_next = 1'b0;
        if (!cfg.rebuild && (32'(head_next) < StoreDepth))
        begin
            rd_valid_next = valid_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= CountReset;
            fwd_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < StoreDepth; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            fwd_reg      <= fwd_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg.rebuild)
            begin
                for (int i = 0; i < StoreDepth; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= head_reg;
    end

    assign head_wide = 32'(head_reg);
    assign product   = head_wide * 32'(cfg.block_size);

    always_comb
    begin
        rsp.block_index = '0;
        rsp.byte_offset = '0;
        rsp.free_count  = count_op;
        if (alloc_ok)
        begin
            rsp.block_index = head_wide[faa_pkg::INDEX_W-1:0];
            rsp.byte_offset = product[faa_pkg::OFFSET_W-1:0];
        end
        if (is_alloc)
        begin
            rsp.status = empty ? faa_pkg::ST_EMPTY : faa_pkg::ST_OK;
        end
        else
        begin
            rsp.status = range_err ? faa_pkg::ST_RANGE : faa_pkg::ST_OK;
        end
    end

    `ASSERT_SAME(a_count_bound, 1'b1, count_reg <= cfg.num_blocks)
    `ASSERT_NEXT(a_alloc_count, alloc_fire, count_reg == $past(count_reg) - 1'b1)
    `ASSERT_NEXT(a_push_link, op.fire && free_ok && !cfg.rebuild, succ == $past(head_reg))

endmodule

// ===== rtl/fixed_block_free_list_allocator_top.sv =====
// Fixed-size block pool allocator with a LIFO free list.
// An item is registered in the input register when it is accepted; its result is
// registered in the output register and offered when that register is free or emptied.
// Throughput: one item per cycle unless replies are held back; the head's successor is
// prefetched from the link store every cycle, with a push forwarded to the next item.
// Reset: the list is rebuilt at once as 0,1,...,num_blocks-1 with block 0 at the
// head; num_blocks resets to 256 and block_size to 32. A register write rebuilds it too.
module fixed_block_free_list_allocator_top #(
    parameter int unsigned MAX_BLOCKS      = faa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned MAX_BLOCK_BYTES = faa_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    faa_req_if.sink                      req,
    faa_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [faa_pkg::PADDR_W-1:0]  paddr,
    input  logic [faa_pkg::PDATA_W-1:0]  pwdata,
    output logic [faa_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    faa_pkg::cfg_t cfg;
    faa_pkg::op_t  op;
    faa_pkg::rsp_t result;

    logic          in_valid_reg, in_valid_next;
    faa_pkg::req_t in_data_reg;
    logic          out_valid_reg, out_valid_next;
    faa_pkg::rsp_t out_data_reg;
    logic          advance;
    logic          take;

    faa_cfg_regs #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    faa_free_list #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .op    (op),
        .rsp   (result)
    );

    // The item in the input register is applied when the output register is free
    // or is being emptied in the same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign op.fire = advance;
    assign op.req  = in_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// ===== bench/tb_fixed_block_free_list_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator_top;
    import faa_pkg::*;

    // Tracks the free list as the block should hold it and keeps the replies it still owes.
    class pool_scoreboard;
        int unsigned link_of [MAX_BLOCKS_DEF];
        int unsigned head_blk;
        int unsigned free_cnt;
        int unsigned pool_blocks;
        int unsigned blk_bytes;
        int unsigned held [$];
        rsp_t        pending_replies [$];
        int          errors;
        int          n_grant;
        int          n_empty;
        int          n_range;
        int          n_return;

        function new();
            pool_blocks = NUM_BLOCKS_RST;
            blk_bytes   = BLOCK_SIZE_RST;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < MAX_BLOCKS_DEF; i++)
                link_of[i] = i + 1;
            head_blk = 0;
            free_cnt = pool_blocks;
            held.delete();
        endfunction

        function void write_reg(reg_index_t r, int unsigned value);
            int unsigned v;
            if (r == REG_NUM_BLOCKS)
            begin
                v = value & 32'h1FF;
                pool_blocks = (v > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : v;
            end
            else
            begin
                v = value & 32'h1FFF;
                blk_bytes = (v > MAX_BLOCK_BYTES_DEF) ? MAX_BLOCK_BYTES_DEF : v;
            end
            rebuild();
        endfunction

        function void note_request(req_t rq);
            rsp_t        want;
            int unsigned blk;
            want = '0;
            want.status = ST_OK;
            if (rq.command == CMD_ALLOC)
            begin
                if (free_cnt == 0)
                begin
                    want.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    blk = head_blk;
                    if (head_blk < MAX_BLOCKS_DEF)
                        head_blk = link_of[head_blk];
                    free_cnt--;
                    want.block_index = blk[7:0];
                    want.byte_offset = 20'(blk * blk_bytes);
                    held.push_back(blk);
                    n_grant++;
                end
            end
            else if (rq.free_index >= pool_blocks)
            begin
                want.status = ST_RANGE;
                n_range++;
            end
            else
            begin
                link_of[rq.free_index] = head_blk;
                head_blk = rq.free_index;
                // A repeated free is pushed again but the count never exceeds the pool.
                if (free_cnt < pool_blocks)
                    free_cnt++;
                n_return++;
            end
            want.free_count = count_t'(free_cnt);
            pending_replies.push_back(want);
        endfunction

        function void check_reply(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply %h with nothing outstanding", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.block_index !== want.block_index)
                $display("%0t: block_index expected %0d actual %0d",
                         $time, want.block_index, got.block_index);
            if (got.byte_offset !== want.byte_offset)
                $display("%0t: byte_offset expected %0d actual %0d",
                         $time, want.byte_offset, got.byte_offset);
            if (got.status !== want.status)
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
            if (got.free_count !== want.free_count)
                $display("%0t: free_count expected %0d actual %0d",
                         $time, want.free_count, got.free_count);
            if (got !== want)
                errors++;
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    faa_req_if req_ch ();
    faa_rsp_if rsp_ch ();

    pool_scoreboard sb = new();

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_ask;
    int hold_left;
    int items_sent;
    int reg_writes;

    fixed_block_free_list_allocator_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d replies outstanding", sb.outstanding());
        $display("** fixed_block_free_list_allocator_top: FAILED **");
        $finish;
    end

    // Reply side: random back-pressure, plus a long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_ask != 0)
            begin
                hold_left = hold_ask;
                hold_ask = 0;
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_reply(rsp_ch.data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.data);
        end
    end

    task automatic send(input command_t cmd, input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data.command <= cmd;
        req_ch.data.free_index <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Lowers valid and waits until every reply owed has come back.
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input reg_index_t r, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(r, value);
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic random_config();
        int unsigned nb;
        int unsigned bs;
        case ($urandom_range(9))
            0: nb = 256;
            1: nb = 1;
            2: nb = $urandom_range(511);
            3, 4, 5, 6: nb = $urandom_range(2, 12);
            default: nb = $urandom_range(1, 256);
        endcase
        case ($urandom_range(7))
            0: bs = 1;
            1: bs = 4096;
            2: bs = $urandom_range(8191);
            default: bs = $urandom_range(1, 4096);
        endcase
        reg_write(REG_BLOCK_SIZE, bs);
        reg_write(REG_NUM_BLOCKS, nb);
    endtask

    // Mixes allocations with frees of blocks that were really handed out, plus some stray and bad frees.
    task automatic random_items(input int count);
        int               pick;
        int               slot;
        logic [INDEX_W-1:0] idx;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            idx = INDEX_W'($urandom_range(255));
            if (pick < 45 || (pick < 80 && sb.held.size() == 0))
                send(CMD_ALLOC, idx);
            else if (pick < 80)
            begin
                slot = $urandom_range(sb.held.size() - 1);
                idx = INDEX_W'(sb.held[slot]);
                sb.held.delete(slot);
                send(CMD_FREE, idx);
            end
            else if (pick < 90)
            begin
                if (sb.pool_blocks != 0)
                    idx = INDEX_W'($urandom_range(sb.pool_blocks - 1));
                send(CMD_FREE, idx);
            end
            else
                send(CMD_FREE, idx);
        end
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct, input bit squeeze);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int seg = 0; seg < 6; seg++)
        begin
            random_config();
            // Hold replies back while items keep coming so the input stalls.
            if (squeeze && seg == 1)
                hold_ask = 80;
            random_items(45);
            wait_quiet();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_ask = 0;
        items_sent = 0;
        reg_writes = 0;
        snd_idle_pct = 31;
        rcv_idle_pct = 59;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pool as it comes out of reset: 256 blocks of 32 bytes.
        send(CMD_ALLOC, 8'hFF);
        send(CMD_ALLOC, 8'h00);
        send(CMD_FREE, 8'd255);
        send(CMD_FREE, 8'd0);
        send(CMD_ALLOC, 8'h00);
        send(CMD_ALLOC, 8'hAA);
        wait_quiet();

        // Single block of the largest size: empty pool, bad index, repeated free.
        reg_write(REG_NUM_BLOCKS, 1);
        reg_write(REG_BLOCK_SIZE, 4096);
        send(CMD_ALLOC, 8'h55);
        send(CMD_ALLOC, 8'h00);
        send(CMD_FREE, 8'd1);
        send(CMD_FREE, 8'd0);
        send(CMD_FREE, 8'd0);
        send(CMD_ALLOC, 8'h00);
        send(CMD_ALLOC, 8'h00);
        wait_quiet();

        // A pool with no blocks refuses everything.
        reg_write(REG_NUM_BLOCKS, 0);
        send(CMD_ALLOC, 8'h00);
        send(CMD_FREE, 8'd0);
        wait_quiet();

        // Oversized count is cut to the maximum, zero size gives zero offsets.
        reg_write(REG_NUM_BLOCKS, 300);
        reg_write(REG_BLOCK_SIZE, 0);
        send(CMD_ALLOC, 8'h00);
        send(CMD_ALLOC, 8'h00);
        wait_quiet();

        // Oversized block size is cut; a free into a full pool leaves the count at the top.
        reg_write(REG_BLOCK_SIZE, 8191);
        reg_write(REG_NUM_BLOCKS, 256);
        send(CMD_FREE, 8'd255);
        send(CMD_ALLOC, 8'h00);
        send(CMD_ALLOC, 8'h00);
        wait_quiet();

        random_phase(31, 59, 1'b0);
        random_phase(59, 31, 1'b0);
        random_phase(0, 0, 1'b1);

        wait_quiet();
        repeat (5) @(posedge clk);

        $display("Sent %0d items across %0d register writes.", items_sent, reg_writes);
        $display("Granted %0d, refused %0d on an empty pool, returned %0d, rejected %0d bad frees.",
                 sb.n_grant, sb.n_empty, sb.n_return, sb.n_range);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** fixed_block_free_list_allocator_top: PASSED **");
        else
            $display("** fixed_block_free_list_allocator_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/faa_pkg.sv
rtl/faa_req_if.sv
rtl/faa_rsp_if.sv
rtl/faa_ram.sv
rtl/faa_cfg_regs.sv
rtl/faa_free_list.sv
rtl/fixed_block_free_list_allocator_top.sv
bench/tb_fixed_block_free_list_allocator_top.sv
